/* rtl/core/doa_pkg.sv */
// doa_pkg: widths, constants, arctangent table and the stage record for the
// direction-of-arrival block. No dependencies.
package doa_pkg;

    localparam int LAG_BITS        = 8;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 14;

    localparam int ANGLE_W        = ANGLE_FRAC_BITS + 3;
    localparam int PRE_SHIFT      = 38 - LAG_BITS;
    localparam int SUM_W          = LAG_BITS + 3;
    localparam int XY_W           = 42;
    localparam int Z_W            = 34;
    localparam int RND_SHIFT      = 30 - ANGLE_FRAC_BITS;
    localparam int ITER_PER_STAGE = 2;
    localparam int NUM_STAGES     = (CORDIC_STAGES + ITER_PER_STAGE - 1) / ITER_PER_STAGE;

    localparam int S_TDATA_W = ((3 * LAG_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // atan(2^-i) in Q30, rounded to nearest
    localparam longint ATAN_Q30 [30] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149,
        64'sd1048576,   64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,
        64'sd32768,     64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128,       64'sd64,
        64'sd32,        64'sd16,        64'sd8,         64'sd4,         64'sd2
    };

    // Q30 to output format: add one half, floor shift
    function automatic longint q30_round(longint z);
        return (z + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    endfunction

    localparam logic signed [ANGLE_W-1:0] PI_OUT       = ANGLE_W'(q30_round(PI_Q30));
    localparam logic signed [ANGLE_W-1:0] HALF_PI_POS  = ANGLE_W'(q30_round(HALF_PI_Q30));
    localparam logic signed [ANGLE_W-1:0] HALF_PI_NEG  = ANGLE_W'(q30_round(-HALF_PI_Q30));
    localparam logic signed [Z_W-1:0]     RND_HALF     = Z_W'(64'sd1 <<< (RND_SHIFT - 1));

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
        logic                      fixed;       // angle known without rotation
        logic                      degen;
        logic signed [ANGLE_W-1:0] fixed_angle;
    } doa_vec_t;

endpackage

/* rtl/core/doa_angle_from_tdoa_lags.sv */
// doa_angle_from_tdoa_lags: top level, arrival angle from three mic lags.
// Depends on doa_pkg, doa_prep, doa_cordic, doa_round.
//
// Usage:
//   Slave channel s_*: one item carries the lags of the east, south and west
//   mics against the north mic, 8-bit two's complement each.
//   Master channel m_*: one item per input item, in order: the arrival angle
//   in radians, signed Q3.13 within +/-pi, and a degenerate flag in m_tuser
//   (set, with angle 0, when both projected components are zero).
//   Pipeline: the input register loads at the accepting edge, then seven
//   CORDIC stages of two rotations each and the output register follow.
//   Throughput: one item per cycle while the output is not stalled; the
//   CORDIC is fully pipelined.
//   Stall: the whole pipeline freezes while m_tvalid is high and m_tready is
//   low; s_tready is then low. With the output register empty or being taken,
//   s_tready is high.
//   Reset: aresetn low empties the pipeline; m_tvalid falls and nothing in
//   flight is delivered.
module doa_angle_from_tdoa_lags (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [doa_pkg::S_TDATA_W-1:0]   s_tdata,   // lag_east, lag_south, lag_west
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [doa_pkg::M_TDATA_W-1:0]   m_tdata,   // angle
    output logic                            m_tuser    // degenerate
);

    logic                                 adv;
    logic                                 prep_vld;
    doa_pkg::doa_vec_t                    prep_vec;
    logic                                 cordic_vld;
    doa_pkg::doa_vec_t                    cordic_vec;
    logic                                 out_valid;
    logic signed [doa_pkg::ANGLE_W-1:0]   angle;
    logic                                 degenerate;

    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    doa_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .vld      (prep_vld),
        .vec      (prep_vec)
    );

    doa_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .vld_in   (prep_vld),
        .vec_in   (prep_vec),
        .vld_out  (cordic_vld),
        .vec_out  (cordic_vec)
    );

    doa_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .vld        (cordic_vld),
        .vec        (cordic_vec),
        .out_valid  (out_valid),
        .angle      (angle),
        .degenerate (degenerate)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = doa_pkg::M_TDATA_W'($unsigned(angle));
    assign m_tuser  = degenerate;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> angle == '0)
        else $error("degenerate item with nonzero angle");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (angle <= doa_pkg::PI_OUT) && (angle >= -doa_pkg::PI_OUT))
        else $error("angle outside +/-pi");

endmodule

/* rtl/core/doa_prep.sv */
// doa_prep: input register; projects the three lags onto x/y, folds the left
// half-plane and sorts out the axis cases. Depends on doa_pkg.
module doa_prep (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            s_tvalid,
    input  logic [doa_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            vld,
    output doa_pkg::doa_vec_t               vec
);

    logic signed [doa_pkg::LAG_BITS-1:0] lag_e;
    logic signed [doa_pkg::LAG_BITS-1:0] lag_s;
    logic signed [doa_pkg::LAG_BITS-1:0] lag_w;
    logic signed [doa_pkg::SUM_W-1:0]    diff;
    logic signed [doa_pkg::SUM_W-1:0]    dx;
    logic signed [doa_pkg::SUM_W-1:0]    dy;
    logic signed [doa_pkg::SUM_W-1:0]    xa;
    logic signed [doa_pkg::SUM_W-1:0]    ya;
    doa_pkg::doa_vec_t                   vec_next;
    doa_pkg::doa_vec_t                   vec_reg;
    logic                                valid_reg;
    logic                                valid_next;

    assign lag_e = s_tdata[doa_pkg::LAG_BITS-1:0];
    assign lag_s = s_tdata[2*doa_pkg::LAG_BITS-1:doa_pkg::LAG_BITS];
    assign lag_w = s_tdata[3*doa_pkg::LAG_BITS-1:2*doa_pkg::LAG_BITS];

    always_comb begin
        diff = doa_pkg::SUM_W'(lag_e) - doa_pkg::SUM_W'(lag_w);
        dx   = (diff <<< 1) + diff;
        dy   = -(doa_pkg::SUM_W'(lag_e) + (doa_pkg::SUM_W'(lag_s) <<< 1)
                 + doa_pkg::SUM_W'(lag_w));
        xa   = dx[doa_pkg::SUM_W-1] ? -dx : dx;
        ya   = dx[doa_pkg::SUM_W-1] ? -dy : dy;

        vec_next.x = doa_pkg::XY_W'(xa) <<< doa_pkg::PRE_SHIFT;
        vec_next.y = doa_pkg::XY_W'(ya) <<< doa_pkg::PRE_SHIFT;
        if (!dx[doa_pkg::SUM_W-1]) begin
            vec_next.z = '0;
        end else if (dy > 0) begin
            vec_next.z = doa_pkg::Z_W'(doa_pkg::PI_Q30);
        end else begin
            vec_next.z = doa_pkg::Z_W'(-doa_pkg::PI_Q30);
        end

        vec_next.fixed = (dx == 0) || (dy == 0);
        vec_next.degen = (dx == 0) && (dy == 0);
        if (vec_next.degen) begin
            vec_next.fixed_angle = '0;
        end else if (dy == 0) begin
            vec_next.fixed_angle = (dx > 0) ? '0 : doa_pkg::PI_OUT;
        end else begin
            vec_next.fixed_angle = (dy > 0) ? doa_pkg::HALF_PI_POS : doa_pkg::HALF_PI_NEG;
        end
    end

    assign valid_next = adv ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_tvalid) begin
            vec_reg <= vec_next;
        end
    end

    assign vld = valid_reg;
    assign vec = vec_reg;

    a_zero_lags_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s_tvalid && (s_tdata[3*doa_pkg::LAG_BITS-1:0] == '0)
        |=> valid_reg && vec_reg.degen && vec_reg.fixed)
        else $error("all-zero lags not flagged degenerate");

endmodule

/* rtl/core/doa_cordic.sv */
// doa_cordic: vectoring CORDIC pipeline, two rotations per register stage.
// Depends on doa_pkg.
module doa_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 vld_in,
    input  doa_pkg::doa_vec_t    vec_in,
    output logic                 vld_out,
    output doa_pkg::doa_vec_t    vec_out
);

    doa_pkg::doa_vec_t stage_vec_reg  [doa_pkg::NUM_STAGES];
    doa_pkg::doa_vec_t stage_vec_next [doa_pkg::NUM_STAGES];
    logic              stage_valid_reg [doa_pkg::NUM_STAGES];

    for (genvar k = 0; k < doa_pkg::NUM_STAGES; k++) begin : g_stage
        doa_pkg::doa_vec_t src;
        doa_pkg::doa_vec_t res;

        if (k == 0) begin : g_first
            assign src = vec_in;
        end else begin : g_rest
            assign src = stage_vec_reg[k-1];
        end

        always_comb begin
            logic signed [doa_pkg::XY_W-1:0] xc;
            logic signed [doa_pkg::XY_W-1:0] yc;
            logic signed [doa_pkg::XY_W-1:0] xs;
            logic signed [doa_pkg::XY_W-1:0] ys;
            logic signed [doa_pkg::Z_W-1:0]  zc;
            res = src;
            xc  = src.x;
            yc  = src.y;
            zc  = src.z;
            xs  = '0;
            ys  = '0;
            for (int j = 0; j < doa_pkg::ITER_PER_STAGE; j++) begin
                if (k * doa_pkg::ITER_PER_STAGE + j < doa_pkg::CORDIC_STAGES) begin
                    xs = xc >>> (k * doa_pkg::ITER_PER_STAGE + j);
                    ys = yc >>> (k * doa_pkg::ITER_PER_STAGE + j);
                    if (yc > 0) begin
                        xc = xc + ys;
                        yc = yc - xs;
                        zc = zc + doa_pkg::Z_W'(
                            doa_pkg::ATAN_Q30[k * doa_pkg::ITER_PER_STAGE + j]);
                    end else begin
                        xc = xc - ys;
                        yc = yc + xs;
                        zc = zc - doa_pkg::Z_W'(
                            doa_pkg::ATAN_Q30[k * doa_pkg::ITER_PER_STAGE + j]);
                    end
                end
            end
            res.x = xc;
            res.y = yc;
            res.z = zc;
        end

        assign stage_vec_next[k] = res;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < doa_pkg::NUM_STAGES; k++) begin
                stage_vec_reg[k] <= stage_vec_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < doa_pkg::NUM_STAGES; k++) begin
                stage_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            stage_valid_reg[0] <= vld_in;
            for (int k = 1; k < doa_pkg::NUM_STAGES; k++) begin
                stage_valid_reg[k] <= stage_valid_reg[k-1];
            end
        end
    end

    assign vld_out = stage_valid_reg[doa_pkg::NUM_STAGES-1];
    assign vec_out = stage_vec_reg[doa_pkg::NUM_STAGES-1];

    // rotation starts in the right half-plane and x only grows
    a_x_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_out && !vec_out.fixed |-> $signed(vec_out.x) > 0)
        else $error("cordic x not positive");

endmodule

/* rtl/core/doa_round.sv */
// doa_round: rounds the Q30 angle, clamps to +/-pi, selects the axis result
// and holds it in the output register. Depends on doa_pkg.
module doa_round (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  vld,
    input  doa_pkg::doa_vec_t                     vec,
    output logic                                  out_valid,
    output logic signed [doa_pkg::ANGLE_W-1:0]    angle,
    output logic                                  degenerate
);

    logic signed [doa_pkg::Z_W-1:0]     z_in;
    logic signed [doa_pkg::Z_W-1:0]     z_rnd;
    logic signed [doa_pkg::ANGLE_W-1:0] angle_next;
    logic signed [doa_pkg::ANGLE_W-1:0] angle_reg;
    logic                               degen_reg;
    logic                               valid_reg;

    always_comb begin
        z_in  = vec.z;
        z_rnd = (z_in + doa_pkg::RND_HALF) >>> doa_pkg::RND_SHIFT;
        if (vec.fixed) begin
            angle_next = vec.fixed_angle;
        end else if (z_rnd > doa_pkg::Z_W'(doa_pkg::PI_OUT)) begin
            angle_next = doa_pkg::PI_OUT;
        end else if (z_rnd < -doa_pkg::Z_W'(doa_pkg::PI_OUT)) begin
            angle_next = -doa_pkg::PI_OUT;
        end else begin
            angle_next = z_rnd[doa_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            angle_reg <= angle_next;
            degen_reg <= vec.degen;
        end
    end

    assign out_valid  = valid_reg;
    assign angle      = angle_reg;
    assign degenerate = degen_reg;

endmodule

/* tb/tb_doa_angle_from_tdoa_lags.sv */
// tb_doa_angle_from_tdoa_lags: self-checking bench for the arrival-angle block.
// Directed lag triples (some with listed results), then random ones; the rest
// use a local CORDIC predictor. Depends on doa_pkg, doa_angle_from_tdoa_lags.
module tb_doa_angle_from_tdoa_lags;

    localparam int NUM_DIRECTED = 24;
    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [doa_pkg::ANGLE_W-1:0] angle;
        logic                               degen;
    } doa_angle_t;

    typedef struct packed {
        logic [doa_pkg::LAG_BITS-1:0]       east;
        logic [doa_pkg::LAG_BITS-1:0]       south;
        logic [doa_pkg::LAG_BITS-1:0]       west;
        logic                               known;
        logic signed [doa_pkg::ANGLE_W-1:0] angle;
        logic                               degen;
    } lag_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [doa_pkg::S_TDATA_W-1:0] s_tdata = '0;   // lag_east, lag_south, lag_west
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [doa_pkg::M_TDATA_W-1:0] m_tdata;        // angle
    logic                          m_tuser;        // degenerate

    doa_angle_t pending_angles [$];
    lag_row_t   directed_rows [NUM_DIRECTED];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         rx_stall = 0;
    bit         quiet = 1'b0;

    doa_angle_from_tdoa_lags dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Q30 to output format: add one half, then floor shift
    function automatic longint q30_to_angle(longint z);
        return (z + (64'sd1 <<< (doa_pkg::RND_SHIFT - 1))) >>> doa_pkg::RND_SHIFT;
    endfunction

    function automatic doa_angle_t predict_angle(logic [doa_pkg::S_TDATA_W-1:0] lags);
        longint     e, s, w, x, y, z, xs, ys, ang, pi_q;
        int         i;
        doa_angle_t r;
        e = longint'($signed(lags[doa_pkg::LAG_BITS-1:0]));
        s = longint'($signed(lags[2*doa_pkg::LAG_BITS-1:doa_pkg::LAG_BITS]));
        w = longint'($signed(lags[3*doa_pkg::LAG_BITS-1:2*doa_pkg::LAG_BITS]));
        x = 3 * (e - w);
        y = -(e + 2 * s + w);
        z = 0;
        pi_q = q30_to_angle(doa_pkg::PI_Q30);
        r.degen = 1'b0;
        if (x == 0 && y == 0) begin
            ang = 0;
            r.degen = 1'b1;
        end else if (y == 0) begin
            ang = (x > 0) ? 64'sd0 : pi_q;
        end else if (x == 0) begin
            ang = q30_to_angle(y > 0 ? doa_pkg::HALF_PI_Q30 : -doa_pkg::HALF_PI_Q30);
        end else begin
            // left half-plane: rotate by pi first
            if (x < 0) begin
                z = (y > 0) ? doa_pkg::PI_Q30 : -doa_pkg::PI_Q30;
                x = -x;
                y = -y;
            end
            x = x <<< doa_pkg::PRE_SHIFT;
            y = y <<< doa_pkg::PRE_SHIFT;
            for (i = 0; i < doa_pkg::CORDIC_STAGES && i < 30; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + doa_pkg::ATAN_Q30[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - doa_pkg::ATAN_Q30[i];
                end
            end
            ang = q30_to_angle(z);
            if (ang > pi_q)
                ang = pi_q;
            if (ang < -pi_q)
                ang = -pi_q;
        end
        r.angle = ang[doa_pkg::ANGLE_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [doa_pkg::LAG_BITS-1:0] corner_lag();
        case ($urandom_range(0, 6))
            0: return 8'h80;
            1: return 8'h81;
            2: return 8'hFF;
            3: return 8'h00;
            4: return 8'h01;
            5: return 8'h7E;
            default: return 8'h7F;
        endcase
    endfunction

    function automatic logic [doa_pkg::S_TDATA_W-1:0] random_lags();
        logic signed [doa_pkg::LAG_BITS-1:0] e, s, w;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                {w, s, e} = doa_pkg::S_TDATA_W'($urandom);
            end
            3, 4: begin
                e = 8'($urandom_range(0, 16)) - 8'd8;
                s = 8'($urandom_range(0, 16)) - 8'd8;
                w = 8'($urandom_range(0, 16)) - 8'd8;
            end
            5: begin
                // on the y axis
                e = 8'($urandom);
                s = 8'($urandom);
                w = e;
            end
            6: begin
                // on the x axis
                e = 8'($urandom_range(0, 126)) - 8'd63;
                s = 8'($urandom_range(0, 63)) - 8'd32;
                w = doa_pkg::LAG_BITS'(-(e + 2 * s));
            end
            7: begin
                // both components zero
                e = 8'($urandom);
                if (e == 8'sh80)
                    e = '0;
                s = -e;
                w = e;
            end
            8: begin
                e = corner_lag();
                s = corner_lag();
                w = corner_lag();
            end
            default: begin
                // close to the pi wrap
                e = -8'($urandom_range(100, 128));
                w = 8'($urandom_range(100, 127));
                s = 8'($urandom_range(0, 8)) - 8'd4;
            end
        endcase
        return {w, s, e};
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic offer_lags(input logic [doa_pkg::S_TDATA_W-1:0] lags,
                              input doa_angle_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lags;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_angles.push_back(want);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_angles.size() != 0);
    endtask

    task automatic check_angle();
        doa_angle_t want;
        if (pending_angles.size() == 0) begin
            note_mismatch($sformatf("item with no expectation: angle %0d degenerate %0b",
                                    $signed(m_tdata[doa_pkg::ANGLE_W-1:0]), m_tuser));
            return;
        end
        want = pending_angles.pop_front();
        if (m_tdata[doa_pkg::ANGLE_W-1:0] !== want.angle)
            note_mismatch($sformatf("angle expected %0d got %0d", want.angle,
                                    $signed(m_tdata[doa_pkg::ANGLE_W-1:0])));
        if (m_tuser !== want.degen)
            note_mismatch($sformatf("degenerate expected %0b got %0b", want.degen, m_tuser));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_angle();
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("doa_angle_from_tdoa_lags verification failed");
            $finish;
        end
    end

    initial begin
        int                            i;
        lag_row_t                      row;
        doa_angle_t                    want;
        logic [doa_pkg::S_TDATA_W-1:0] lags;
        directed_rows = '{
            '{8'h00, 8'h00, 8'h00, 1'b1, 16'sd0,      1'b1},
            '{8'h05, 8'hFB, 8'h05, 1'b1, 16'sd0,      1'b1},
            '{8'h80, 8'h80, 8'h80, 1'b1, 16'sd12868,  1'b0},
            '{8'h7F, 8'h7F, 8'h7F, 1'b1, -16'sd12868, 1'b0},
            '{8'h01, 8'h00, 8'hFF, 1'b1, 16'sd0,      1'b0},
            '{8'hFF, 8'h00, 8'h01, 1'b1, 16'sd25736,  1'b0},
            '{8'h7F, 8'h00, 8'h81, 1'b1, 16'sd0,      1'b0},
            '{8'h81, 8'h00, 8'h7F, 1'b1, 16'sd25736,  1'b0},
            '{8'h00, 8'h01, 8'h00, 1'b1, -16'sd12868, 1'b0},
            '{8'h00, 8'hFF, 8'h00, 1'b1, 16'sd12868,  1'b0},
            '{8'h80, 8'h7F, 8'h80, 1'b1, 16'sd12868,  1'b0},
            '{8'h7F, 8'h80, 8'h7F, 1'b1, 16'sd12868,  1'b0},
            '{8'h55, 8'hAA, 8'h55, 1'b1, 16'sd12868,  1'b0},
            '{8'hAA, 8'h55, 8'hAA, 1'b1, 16'sd12868,  1'b0},
            '{8'h7F, 8'h00, 8'h80, 1'b0, 16'sd0,      1'b0},
            '{8'h80, 8'h00, 8'h7F, 1'b0, 16'sd0,      1'b0},
            '{8'h80, 8'hFF, 8'h7F, 1'b0, 16'sd0,      1'b0},
            '{8'h81, 8'h01, 8'h7F, 1'b0, 16'sd0,      1'b0},
            '{8'h01, 8'h00, 8'h00, 1'b0, 16'sd0,      1'b0},
            '{8'h00, 8'h00, 8'h01, 1'b0, 16'sd0,      1'b0},
            '{8'h03, 8'hFF, 8'h00, 1'b0, 16'sd0,      1'b0},
            '{8'h7F, 8'h80, 8'h80, 1'b0, 16'sd0,      1'b0},
            '{8'h80, 8'h7F, 8'h7F, 1'b0, 16'sd0,      1'b0},
            '{8'h55, 8'hD5, 8'h00, 1'b0, 16'sd0,      1'b0}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < NUM_DIRECTED; i++) begin
            row  = directed_rows[i];
            lags = {row.west, row.south, row.east};
            if (row.known) begin
                want.angle = row.angle;
                want.degen = row.degen;
            end else begin
                want = predict_angle(lags);
            end
            offer_lags(lags, want);
        end
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            quiet = (i % 400) >= 300;
            lags = random_lags();
            offer_lags(lags, predict_angle(lags));
        end
        quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("doa_angle_from_tdoa_lags verification clean");
        else
            $display("doa_angle_from_tdoa_lags verification failed");
        $finish;
    end

endmodule
